/* src/nprs_pkg.sv */
// Shared types and constants of the NAND page read sequencer.
`default_nettype none
package nprs_pkg;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_STATUS = 2'd1,
    ACT_DATA   = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    OP_SELECT   = 3'd0,
    OP_CMD      = 3'd1,
    OP_ADDR     = 3'd2,
    OP_WAIT     = 3'd3,
    OP_STORE    = 3'd4,
    OP_DESELECT = 3'd5,
    OP_IGNORED  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_READ
  } phase_t;

  typedef enum logic [1:0] {
    SPLIT_IDLE,
    SPLIT_MUL,
    SPLIT_SUB
  } split_t;

  typedef enum logic [2:0] {
    JOB_IGNORED,
    JOB_EMPTY,
    JOB_OPEN,
    JOB_STORE,
    JOB_STORE_END,
    JOB_STORE_TURN
  } job_kind_t;

  localparam int ColW   = 12;
  localparam int PageW  = 24;
  localparam int JobDepth = 4;

  localparam logic [7:0] CmdReadSetup = 8'h00;
  localparam logic [7:0] CmdReadGo    = 8'h30;

  typedef struct packed {
    job_kind_t         kind;
    logic [7:0]        data;
    logic [31:0]       index;
    logic [ColW-1:0]   column;
    logic [PageW-1:0]  page;
  } job_t;

endpackage
`default_nettype wire

/* src/nprs_in_if.sv */
// Input channel of the NAND page read sequencer.
`default_nettype none
interface nprs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] byte_address;
  logic [31:0] byte_count;
  logic        ready_bit;
  logic [7:0]  flash_byte;

  modport source(output valid, action, byte_address, byte_count, ready_bit, flash_byte,
                 input ready);
  modport sink(input valid, action, byte_address, byte_count, ready_bit, flash_byte,
               output ready);
endinterface
`default_nettype wire

/* src/nprs_out_if.sv */
// Result channel of the NAND page read sequencer.
`default_nettype none
interface nprs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [7:0]  bus_byte;
  logic [31:0] buffer_index;
  logic        transfer_done;
  logic        last_of_run;

  modport source(output valid, operation, bus_byte, buffer_index, transfer_done, last_of_run,
                 input ready);
  modport sink(input valid, operation, bus_byte, buffer_index, transfer_done, last_of_run,
               output ready);
endinterface
`default_nettype wire

/* src/nprs_front.sv */
// Front part: accepts items, keeps the transfer state and queues jobs.
`default_nettype none
module nprs_front #(
  parameter int PAGE_BYTES = 2048
) (
  input  logic           clk,
  input  logic           rst,
  nprs_in_if.sink        req,
  output logic           push_valid,
  input  logic           push_ready,
  output nprs_pkg::job_t push_job
);

  localparam int Shift = $clog2(PAGE_BYTES);
  localparam logic [64:0] Recip =
    65'(((64'd1 << (32 + Shift)) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));
  localparam logic [nprs_pkg::ColW-1:0] ColLast = nprs_pkg::ColW'(PAGE_BYTES - 1);

  nprs_pkg::phase_t phase, phase_next;
  nprs_pkg::split_t split, split_next;
  logic [31:0] current_address, current_address_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] next_index, next_index_next;
  logic [nprs_pkg::ColW-1:0] column, column_next;
  logic [31:0] split_addr, split_addr_next;
  logic [nprs_pkg::PageW-1:0] split_page;
  nprs_pkg::job_t pend, pend_next;

  logic accept;
  logic [64:0] product;
  logic [31:0] remainder;

  assign req.ready = (split == nprs_pkg::SPLIT_IDLE) && push_ready;
  assign accept = req.valid && req.ready;
  assign product = 65'(split_addr) * Recip;
  assign remainder = split_addr - 32'(split_page) * 32'(PAGE_BYTES);

  always_comb begin
    phase_next = phase;
    split_next = split;
    current_address_next = current_address;
    bytes_left_next = bytes_left;
    next_index_next = next_index;
    column_next = column;
    split_addr_next = split_addr;
    pend_next = pend;
    push_valid = 1'b0;
    push_job = '{kind: nprs_pkg::JOB_IGNORED, data: req.flash_byte, index: next_index,
                 column: '0, page: '0};
    unique case (split)
      nprs_pkg::SPLIT_IDLE: begin
        if (accept) begin
          if (req.action == nprs_pkg::ACT_START && phase == nprs_pkg::PH_IDLE) begin
            if (req.byte_count == 32'd0) begin
              push_valid = 1'b1;
              push_job.kind = nprs_pkg::JOB_EMPTY;
            end else begin
              current_address_next = req.byte_address;
              bytes_left_next = req.byte_count;
              next_index_next = 32'd0;
              phase_next = nprs_pkg::PH_WAIT;
              split_addr_next = req.byte_address;
              split_next = nprs_pkg::SPLIT_MUL;
              pend_next = push_job;
              pend_next.kind = nprs_pkg::JOB_OPEN;
            end
          end else if (req.action == nprs_pkg::ACT_STATUS && phase == nprs_pkg::PH_WAIT) begin
            if (req.ready_bit) begin
              phase_next = nprs_pkg::PH_READ;
            end
          end else if (req.action == nprs_pkg::ACT_DATA && phase == nprs_pkg::PH_READ) begin
            next_index_next = next_index + 32'd1;
            current_address_next = current_address + 32'd1;
            bytes_left_next = bytes_left - 32'd1;
            column_next = column + 1'b1;
            if (bytes_left == 32'd1) begin
              push_valid = 1'b1;
              push_job.kind = nprs_pkg::JOB_STORE_END;
              phase_next = nprs_pkg::PH_IDLE;
            end else if (column == ColLast) begin
              column_next = '0;
              phase_next = nprs_pkg::PH_WAIT;
              split_addr_next = current_address + 32'd1;
              split_next = nprs_pkg::SPLIT_MUL;
              pend_next = push_job;
              pend_next.kind = nprs_pkg::JOB_STORE_TURN;
            end else begin
              push_valid = 1'b1;
              push_job.kind = nprs_pkg::JOB_STORE;
            end
          end else begin
            push_valid = 1'b1;
            push_job.kind = nprs_pkg::JOB_IGNORED;
          end
        end
      end
      nprs_pkg::SPLIT_MUL: begin
        split_next = nprs_pkg::SPLIT_SUB;
      end
      nprs_pkg::SPLIT_SUB: begin
        push_valid = 1'b1;
        push_job = pend;
        push_job.column = remainder[nprs_pkg::ColW-1:0];
        push_job.page = split_page;
        split_next = nprs_pkg::SPLIT_IDLE;
        if (pend.kind == nprs_pkg::JOB_OPEN) begin
          column_next = remainder[nprs_pkg::ColW-1:0];
        end
      end
      default: begin
        split_next = nprs_pkg::SPLIT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= nprs_pkg::PH_IDLE;
      split <= nprs_pkg::SPLIT_IDLE;
      current_address <= 32'd0;
      bytes_left <= 32'd0;
      next_index <= 32'd0;
      column <= '0;
    end else begin
      phase <= phase_next;
      split <= split_next;
      current_address <= current_address_next;
      bytes_left <= bytes_left_next;
      next_index <= next_index_next;
      column <= column_next;
    end
  end

  always_ff @(posedge clk) begin
    split_addr <= split_addr_next;
    split_page <= nprs_pkg::PageW'(product >> (32 + Shift));
    pend <= pend_next;
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("Job pushed into a full queue.");

  a_read_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == nprs_pkg::PH_READ |-> bytes_left != 32'd0)
    else $error("Reading with no bytes left.");

  a_split_blocks_input: assert property (@(posedge clk) disable iff (rst)
    split == nprs_pkg::SPLIT_MUL |=> split == nprs_pkg::SPLIT_SUB && !accept)
    else $error("Address split did not complete in order.");

endmodule
`default_nettype wire

/* src/nprs_job_fifo.sv */
// Short job queue between the front and back parts.
`default_nettype none
module nprs_job_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  nprs_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output nprs_pkg::job_t pop_job
);

  localparam int PtrW = $clog2(nprs_pkg::JobDepth);
  localparam int CntW = $clog2(nprs_pkg::JobDepth + 1);

  nprs_pkg::job_t mem [nprs_pkg::JobDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic do_push, do_pop;

  assign push_ready = count != CntW'(nprs_pkg::JobDepth);
  assign pop_valid = count != '0;
  assign pop_job = mem[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(nprs_pkg::JobDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(nprs_pkg::JobDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/nprs_back.sv */
// Back part: jobs into bus ops, one result a cycle unless stalled.
`default_nettype none
module nprs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  nprs_pkg::job_t pop_job,
  nprs_out_if.source     rsp
);

  localparam logic [3:0] StepHead    = 4'd0;
  localparam logic [3:0] StepCmdRead = 4'd1;
  localparam logic [3:0] StepColLo   = 4'd2;
  localparam logic [3:0] StepColHi   = 4'd3;
  localparam logic [3:0] StepPage0   = 4'd4;
  localparam logic [3:0] StepPage1   = 4'd5;
  localparam logic [3:0] StepPage2   = 4'd6;
  localparam logic [3:0] StepCmdGo   = 4'd7;
  localparam logic [3:0] StepWait    = 4'd8;

  nprs_pkg::job_t job;
  logic busy;
  logic [3:0] step;
  logic [3:0] last_step;
  logic advance, load, is_last;

  nprs_pkg::op_t op;
  logic [7:0] bus_byte;
  logic [31:0] buffer_index;
  logic done;

  always_comb begin
    op = nprs_pkg::OP_IGNORED;
    bus_byte = 8'd0;
    buffer_index = 32'd0;
    done = 1'b0;
    last_step = StepHead;
    unique case (job.kind)
      nprs_pkg::JOB_EMPTY, nprs_pkg::JOB_STORE_END: last_step = StepCmdRead;
      nprs_pkg::JOB_OPEN, nprs_pkg::JOB_STORE_TURN: last_step = StepWait;
      default: last_step = StepHead;
    endcase
    if (step == StepHead) begin
      unique case (job.kind)
        nprs_pkg::JOB_EMPTY, nprs_pkg::JOB_OPEN: op = nprs_pkg::OP_SELECT;
        nprs_pkg::JOB_STORE, nprs_pkg::JOB_STORE_END, nprs_pkg::JOB_STORE_TURN: begin
          op = nprs_pkg::OP_STORE;
          bus_byte = job.data;
          buffer_index = job.index;
        end
        default: op = nprs_pkg::OP_IGNORED;
      endcase
    end else if (job.kind == nprs_pkg::JOB_EMPTY || job.kind == nprs_pkg::JOB_STORE_END) begin
      op = nprs_pkg::OP_DESELECT;
      done = 1'b1;
    end else begin
      unique case (step)
        StepCmdRead: begin
          op = nprs_pkg::OP_CMD;
          bus_byte = nprs_pkg::CmdReadSetup;
        end
        StepColLo: begin
          op = nprs_pkg::OP_ADDR;
          bus_byte = job.column[7:0];
        end
        StepColHi: begin
          op = nprs_pkg::OP_ADDR;
          bus_byte = 8'(job.column[nprs_pkg::ColW-1:8]);
        end
        StepPage0: begin
          op = nprs_pkg::OP_ADDR;
          bus_byte = job.page[7:0];
        end
        StepPage1: begin
          op = nprs_pkg::OP_ADDR;
          bus_byte = job.page[15:8];
        end
        StepPage2: begin
          op = nprs_pkg::OP_ADDR;
          bus_byte = job.page[23:16];
        end
        StepCmdGo: begin
          op = nprs_pkg::OP_CMD;
          bus_byte = nprs_pkg::CmdReadGo;
        end
        default: op = nprs_pkg::OP_WAIT;
      endcase
    end
  end

  assign is_last = step == last_step;
  assign advance = busy && (!rsp.valid || rsp.ready);
  assign load = !busy || (advance && is_last);
  assign pop_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= StepHead;
      rsp.valid <= 1'b0;
    end else begin
      if (advance) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (load) begin
        busy <= pop_valid;
        step <= StepHead;
      end else if (advance) begin
        step <= step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= pop_job;
    end
    if (advance) begin
      rsp.operation <= op;
      rsp.bus_byte <= bus_byte;
      rsp.buffer_index <= buffer_index;
      rsp.transfer_done <= done;
      rsp.last_of_run <= is_last;
    end
  end

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.transfer_done |->
      rsp.operation == nprs_pkg::OP_DESELECT && rsp.last_of_run)
    else $error("Transfer done flagged on a result that does not end a run.");

  a_index_only_on_store: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.operation != nprs_pkg::OP_STORE |-> rsp.buffer_index == 32'd0)
    else $error("Buffer index set on a result that is not a store.");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= last_step)
    else $error("Job step ran past its last result.");

endmodule
`default_nettype wire

/* src/nand_page_read_sequencer_core.sv */
// Top level of the NAND page read sequencer.
`default_nettype none
// Host-side sequencer for a large-page NAND read with a five-byte address. The back part
// issues one result item per clock while the result channel takes them and jobs are queued;
// a start item gives nine results (two for a zero length), a data byte that ends a page
// gives nine and one that ends the transfer gives two; a plain data byte gives one. A start
// item or a page-ending data byte holds input ready low through the SPLIT_MUL and SPLIT_SUB
// states while the address is split into page and column by a constant reciprocal multiply.
// A four-entry job queue lets the input side run ahead of the result side.
module nand_page_read_sequencer_core #(
  parameter int PAGE_BYTES = 2048
) (
  input  logic       clk,
  input  logic       rst,
  nprs_in_if.sink    req,
  nprs_out_if.source rsp
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  nprs_pkg::job_t push_job, pop_job;

  nprs_front #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job)
  );

  nprs_job_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job)
  );

  nprs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_job  (pop_job),
    .rsp      (rsp)
  );

endmodule
`default_nettype wire
